>>> sv/pss_pkg.sv
// Package for the point sort unit: shared point type, command/status structs,
// controller state enum and the sort-order compare function.
// No dependencies.
package pss_pkg;

   // Store capacity and derived widths
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;

   // One stored point: x in the upper half, y in the lower half
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } pss_point_type;

   localparam int POINT_W = $bits(pss_point_type);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHECK,
      ST_INS_CMP,
      ST_OUT_READ,
      ST_OUT_CAP,
      ST_OUT_WAIT
   } pss_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // take the incoming beat
      logic rd_prev;   // read entry idx-1
      logic shift_wr;  // move entry idx-1 up to idx, step idx down
      logic place_wr;  // write the held point at idx, bump the count
      logic out_rd;    // read entry idx for output
      logic out_cap;   // load the output register
      logic out_next;  // output beat taken, advance
   } pss_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic store_full;
      logic idx_zero;
      logic ahead;      // held point sorts ahead of the entry just read
      logic held_last;  // held beat carried last_point
      logic out_taken;  // output beat accepted this cycle
      logic out_final;  // output register holds the final point of the run
   } pss_status_type;

   // True when point a must be emitted ahead of point b
   function automatic logic pss_goes_before(input pss_point_type a,
                                            input pss_point_type b);
      if (a.x != b.x)
         return a.x < b.x;
      return a.y > b.y;
   endfunction

endpackage

>>> sv/point_sort_x_asc_y_desc_unit.sv
// Point sort unit: loads points one per beat (insertion sort into the store)
// and emits them by x ascending, then y descending, after the last point.
// Insertion: a point is dropped if the store is full; else each stored point it
//   passes (0..63) costs a read plus a shift before it is written where it settles.
// Output: one sorted point at a time, each read, captured and held until taken.
// Reset (synchronous, active high) empties the store and clears the drop flag.
module point_sort_x_asc_y_desc_unit
   import pss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_sorted_x,
   output logic signed [COORD_W-1:0] rsp_sorted_y,
   output logic                      rsp_last_out,
   output logic                      rsp_overflow
);

   pss_cmd_type    cmd;
   pss_status_type status;

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pss_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sorted_x   (rsp_sorted_x),
      .rsp_sorted_y   (rsp_sorted_y),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

>>> sv/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pss_ctrl.sv
// Controller for the point sort unit: sequences insertion of each point and
// the sorted output run. Depends on pss_pkg.
module pss_ctrl
   import pss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  pss_status_type status,
   output pss_cmd_type    cmd
);

   pss_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_INS_CHECK;
         end
         ST_INS_CHECK: begin
            // a dropped point skips insertion
            if (status.store_full)
               state_in = status.held_last ? ST_OUT_READ : ST_IDLE;
            else if (status.idx_zero)
               state_in = status.held_last ? ST_OUT_READ : ST_IDLE;
            else
               state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            if (status.ahead)
               state_in = ST_INS_CHECK;
            else
               state_in = status.held_last ? ST_OUT_READ : ST_IDLE;
         end
         ST_OUT_READ: state_in = ST_OUT_CAP;
         ST_OUT_CAP:  state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (status.out_taken)
               state_in = status.out_final ? ST_IDLE : ST_OUT_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_INS_CHECK: begin
            if (!status.store_full) begin
               if (status.idx_zero)
                  cmd.place_wr = 1'b1;
               else
                  cmd.rd_prev = 1'b1;
            end
         end
         ST_INS_CMP: begin
            if (status.ahead)
               cmd.shift_wr = 1'b1;
            else
               cmd.place_wr = 1'b1;
         end
         ST_OUT_READ: cmd.out_rd  = 1'b1;
         ST_OUT_CAP:  cmd.out_cap = 1'b1;
         ST_OUT_WAIT: cmd.out_next = status.out_taken;
         default: ;
      endcase
   end

endmodule

>>> sv/pss_dpath.sv
// Datapath for the point sort unit: point store, count, drop flag, insertion
// index and output register. Depends on pss_pkg and pss_ram.
module pss_dpath
   import pss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  pss_cmd_type               cmd,
   output pss_status_type            status,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_sorted_x,
   output logic signed [COORD_W-1:0] rsp_sorted_y,
   output logic                      rsp_last_out,
   output logic                      rsp_overflow
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   pss_point_type     held_ff, held_in;
   logic              held_last_ff, held_last_in;
   logic              held_drop_ff, held_drop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pss_point_type     out_pt_ff, out_pt_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   pss_point_type     ram_wr_data;
   pss_point_type     ram_rd_data;
   logic              store_full;
   logic              at_final;

   assign store_full = (count_ff == CNT_W'(MAX_POINTS));
   assign at_final   = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;

   // store access
   assign ram_wr_en   = cmd.shift_wr | cmd.place_wr;
   assign ram_wr_data = cmd.shift_wr ? ram_rd_data : held_ff;
   assign ram_rd_addr = cmd.rd_prev ? idx_ff - ADDR_W'(1) : idx_ff;

   pss_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_prev | cmd.out_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values
   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      held_last_in = held_last_ff;
      held_drop_in = held_drop_ff;
      rsp_valid_in = rsp_valid_ff;
      out_pt_in    = out_pt_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      // new beat: full store drops it and starts any run at entry zero
      if (cmd.capture) begin
         held_in.x    = req_point_x;
         held_in.y    = req_point_y;
         held_last_in = req_last_point;
         held_drop_in = store_full;
         if (store_full) begin
            dropped_in = 1'b1;
            idx_in     = '0;
         end else begin
            idx_in = count_ff[ADDR_W-1:0];
         end
      end

      // insertion steps
      if (cmd.shift_wr)
         idx_in = idx_ff - ADDR_W'(1);
      if (cmd.place_wr) begin
         count_in = count_ff + CNT_W'(1);
         idx_in   = '0;
      end

      // output run
      if (cmd.out_cap) begin
         out_pt_in    = ram_rd_data;
         out_last_in  = at_final;
         out_ovf_in   = dropped_ff;
         rsp_valid_in = 1'b1;
      end
      if (cmd.out_next) begin
         rsp_valid_in = 1'b0;
         idx_in       = idx_ff + ADDR_W'(1);
         if (out_last_ff) begin
            count_in   = '0;
            dropped_in = 1'b0;
            idx_in     = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         held_last_ff <= 1'b0;
         held_drop_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         held_last_ff <= held_last_in;
         held_drop_ff <= held_drop_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      out_pt_ff   <= out_pt_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // status
   always_comb begin
      status.store_full = held_drop_ff;
      status.idx_zero   = (idx_ff == '0);
      status.ahead      = pss_goes_before(held_ff, ram_rd_data);
      status.held_last  = held_last_ff;
      status.out_taken  = rsp_valid_ff & ~rsp_stall;
      status.out_final  = out_last_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sorted_x = out_pt_ff.x;
   assign rsp_sorted_y = out_pt_ff.y;
   assign rsp_last_out = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> store_full)
      else $error("drop flag set while store has room");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, idx_ff} < count_ff))
      else $error("output index beyond stored points");

   assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> !status.idx_zero)
      else $error("shift below entry zero");

endmodule

>>> test/point_sort_checker.sv
// Checker for the point sort unit: watches the point and sorted-point channels,
// predicts each sorted run from the accepted points and compares beat by beat.
// Depends on pss_pkg for the point type and store capacity.
`timescale 1ns / 1ps

module point_sort_checker
   import pss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      req_last_point,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [COORD_W-1:0] rsp_sorted_x,
   input  logic signed [COORD_W-1:0] rsp_sorted_y,
   input  logic                      rsp_last_out,
   input  logic                      rsp_overflow,
   output int                        fail_count,
   output int                        pending_beats,
   output int                        sets_seen,
   output int                        results_seen,
   output int                        overflow_sets
);

   localparam int REPORT_LIMIT = 10;

   // One expected output beat
   typedef struct {
      pss_point_type pt;
      logic          last;
      logic          ovf;
   } sorted_beat_type;

   pss_point_type   stored_pts [MAX_POINTS];
   int              stored_cnt;
   bit              drop_seen;
   sorted_beat_type sorted_run [$];
   int              mismatches;
   int              n_sets;
   int              n_results;
   int              n_ovf_sets;

   initial begin
      stored_cnt    = 0;
      drop_seen     = 0;
      mismatches    = 0;
      n_sets        = 0;
      n_results     = 0;
      n_ovf_sets    = 0;
   end

   // Unsigned sort key: x ascending in the top half, y descending in the bottom
   function automatic logic [2*COORD_W-1:0] order_key(input pss_point_type p);
      return {~p.x[COORD_W-1], p.x[COORD_W-2:0], p.y[COORD_W-1], ~p.y[COORD_W-2:0]};
   endfunction

   // Store one accepted point; on the last point sort the set and queue the run
   task automatic load_point(input pss_point_type p, input logic last_flag);
      int            i;
      int            j;
      pss_point_type v;
      if (stored_cnt < MAX_POINTS) begin
         stored_pts[stored_cnt] = p;
         stored_cnt++;
      end else begin
         drop_seen = 1'b1;
      end
      if (last_flag) begin
         for (i = 1; i < stored_cnt; i++) begin
            v = stored_pts[i];
            j = i;
            while (j > 0 && order_key(v) < order_key(stored_pts[j-1])) begin
               stored_pts[j] = stored_pts[j-1];
               j--;
            end
            stored_pts[j] = v;
         end
         for (i = 0; i < stored_cnt; i++)
            sorted_run.push_back('{pt: stored_pts[i], last: (i == stored_cnt - 1),
                                   ovf: drop_seen});
         n_sets++;
         if (drop_seen)
            n_ovf_sets++;
         stored_cnt = 0;
         drop_seen  = 1'b0;
      end
   endtask

   // Compare one output beat with the oldest expectation
   task automatic check_beat();
      sorted_beat_type want;
      n_results++;
      if (sorted_run.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected sorted beat x=%0d y=%0d last=%0b ovf=%0b",
                     $realtime, rsp_sorted_x, rsp_sorted_y, rsp_last_out, rsp_overflow);
      end else begin
         want = sorted_run.pop_front();
         if (rsp_sorted_x !== want.pt.x || rsp_sorted_y !== want.pt.y ||
             rsp_last_out !== want.last || rsp_overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch: expected x=%0d y=%0d last=%0b ovf=%0b",
                        $realtime, want.pt.x, want.pt.y, want.last, want.ovf);
               $display("    got x=%0d y=%0d last=%0b ovf=%0b",
                        rsp_sorted_x, rsp_sorted_y, rsp_last_out, rsp_overflow);
            end
         end
      end
   endtask

   // Sample both channels at the edge; points are taken before results
   always @(posedge clock) begin
      if (reset) begin
         stored_cnt = 0;
         drop_seen  = 1'b0;
         sorted_run.delete();
      end else begin
         if (req_valid && !req_stall)
            load_point('{x: req_point_x, y: req_point_y}, req_last_point);
         if (rsp_valid && !rsp_stall)
            check_beat();
      end
      fail_count    <= mismatches;
      pending_beats <= sorted_run.size();
      sets_seen     <= n_sets;
      results_seen  <= n_results;
      overflow_sets <= n_ovf_sets;
   end

endmodule

>>> test/point_sort_x_asc_y_desc_unit_test.sv
// Testbench top for the point sort unit: clock, reset, point sets in bursts,
// random output stalls with one long hold-off, watchdog and verdict.
// Depends on pss_pkg, point_sort_x_asc_y_desc_unit and point_sort_checker.
`timescale 1ns / 1ps

module point_sort_x_asc_y_desc_unit_test;
   import pss_pkg::*;

   localparam int ITEMS          = 370;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 200;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;
   typedef enum int {PTS_WIDE, PTS_CLUSTER, PTS_MIXED} set_flavor_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic                      req_last_point = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_sorted_x;
   logic signed [COORD_W-1:0] rsp_sorted_y;
   logic                      rsp_last_out;
   logic                      rsp_overflow;

   int fail_count;
   int pending_beats;
   int sets_seen;
   int results_seen;
   int overflow_sets;
   int points_offered = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;

   point_sort_x_asc_y_desc_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sorted_x   (rsp_sorted_x),
      .rsp_sorted_y   (rsp_sorted_y),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflow   (rsp_overflow)
   );

   point_sort_checker u_checker (.*);

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("point_sort_x_asc_y_desc_unit regression: fail");
            $finish;
         end
      end
   end

   // Receiver: stall patterns in random segments, one long hold-off mid-run
   initial begin
      stall_mode_type mode;
      int             seg;
      bit             held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= 20 && rsp_valid) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         seg  = $urandom_range(8, 60);
         repeat (seg) begin
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return 16'sh8000;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sh7fff;
      endcase
   endfunction

   // Random point; the cluster flavor forces many equal-x ties and duplicates
   function automatic pss_point_type random_point(input set_flavor_type flavor);
      pss_point_type  p;
      set_flavor_type pick;
      pick = (flavor == PTS_MIXED) ? set_flavor_type'($urandom_range(0, 3)) : flavor;
      case (pick)
         PTS_WIDE: begin
            p.x = COORD_W'($urandom());
            p.y = COORD_W'($urandom());
         end
         PTS_CLUSTER: begin
            p.x = COORD_W'(int'($urandom_range(0, 6)) - 3);
            p.y = COORD_W'(int'($urandom_range(0, 8)) - 4);
         end
         default: begin
            p.x = extreme_coord();
            p.y = extreme_coord();
         end
      endcase
      return p;
   endfunction

   // Drive one set, last point flagged; bursts end with a random gap
   task automatic send_set(input pss_point_type pts[$], input bit closing);
      int k;
      for (k = 0; k < pts.size(); k++) begin
         req_valid      <= 1'b1;
         req_point_x    <= pts[k].x;
         req_point_y    <= pts[k].y;
         req_last_point <= (k == pts.size() - 1);
         do @(posedge clock); while (req_stall);
         points_offered++;
         if (closing && k == pts.size() - 1) begin
            req_valid <= 1'b0;
         end else if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      pss_point_type  pts[$];
      set_flavor_type flavor;
      int             n;
      int             set_idx;
      int             r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Run of a single point at the corner of the range
      pts = '{'{x: 16'sh8000, y: 16'sh7fff}};
      send_set(pts, 1'b0);
      // Extremes, equal x with y above and below, a duplicate point
      pts = '{'{x: 16'sh7fff, y: 16'sh8000}, '{x: 16'sh8000, y: 16'sh8000},
              '{x: 16'sd0, y: 16'sd0},       '{x: -16'sd1, y: -16'sd1},
              '{x: 16'sd0, y: 16'sd5},       '{x: 16'sd0, y: -16'sd5},
              '{x: 16'sd0, y: 16'sd5},       '{x: 16'sh7fff, y: 16'sh7fff},
              '{x: 16'sh8000, y: 16'sh7fff}};
      send_set(pts, 1'b0);
      // All x equal: order decided by y alone
      pts = '{'{x: 16'sd7, y: 16'sd1},      '{x: 16'sd7, y: -16'sd1},
              '{x: 16'sd7, y: 16'sh7fff},   '{x: 16'sd7, y: 16'sh8000}};
      send_set(pts, 1'b0);
      // Points arriving in reverse order
      pts = '{'{x: 16'sd3, y: 16'sd0}, '{x: 16'sd2, y: 16'sd0}, '{x: 16'sd1, y: 16'sd0}};
      send_set(pts, 1'b0);

      // Random sets: mostly small, some filling the store, some overflowing it
      set_idx = 0;
      while (points_offered < ITEMS) begin
         r = $urandom_range(0, 99);
         if (set_idx == 1)
            n = MAX_POINTS;
         else if (set_idx == 3)
            n = MAX_POINTS + 4;
         else if (r < 70)
            n = $urandom_range(1, 8);
         else if (r < 90)
            n = $urandom_range(9, 30);
         else if (r < 96)
            n = MAX_POINTS;
         else
            n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
         flavor = set_flavor_type'($urandom_range(0, 2));
         pts.delete();
         repeat (n) pts.push_back(random_point(flavor));
         send_set(pts, points_offered + n >= ITEMS);
         set_idx++;
      end

      // Drain the last run, then let the block settle
      do @(posedge clock); while (pending_beats != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d points in %0d sets, %0d of them overflowing the store;",
               points_offered, sets_seen, overflow_sets);
      $display("checked %0d sorted beats, %0d mismatching.", results_seen, fail_count);
      if (fail_count == 0)
         $display("point_sort_x_asc_y_desc_unit regression: pass");
      else
         $display("point_sort_x_asc_y_desc_unit regression: fail");
      $finish;
   end

endmodule

>>> files.f
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pss_ctrl.sv
sv/pss_dpath.sv
sv/point_sort_x_asc_y_desc_unit.sv
test/point_sort_checker.sv
test/point_sort_x_asc_y_desc_unit_test.sv
